### hdl/pnq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the palette nearest-color quantizer.
// Depends on nothing; every other file of the block uses it.
package pnq_pkg;

  localparam int DEF_ENTRIES    = 256;
  localparam int DEFAULT_COLORS = 16;
  localparam int CH_W           = 8;
  localparam int COUNT_W        = 9;
  localparam int DIST_W         = 18;
  localparam int SQ_W           = 16;
  localparam int WORD_W         = 32;
  localparam int PROD_W         = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int ALPHA_ROUND    = 128;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_QUANT  = 2'd1;
  localparam logic [1:0] FUNC_EXPAND = 2'd2;

  localparam logic REG_PALETTE_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]        func;
    logic [CH_W-1:0]   idx;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   alpha;
    logic              last;
    logic [CH_W-1:0]   sel;
    logic [DIST_W-1:0] best_dist;
    logic [WORD_W-1:0] word;
  } item_t;

  // Default colors, packed as {alpha, blue, green, red}.
  function automatic logic [WORD_W-1:0] ega_color(input logic [3:0] i);
    logic [WORD_W-1:0] w;
    case (i)
      4'd0:    w = 32'hFF000000;
      4'd1:    w = 32'hFF00007F;
      4'd2:    w = 32'hFF007F00;
      4'd3:    w = 32'hFF007F7F;
      4'd4:    w = 32'hFF7F0000;
      4'd5:    w = 32'hFF7F007F;
      4'd6:    w = 32'hFF7F7F00;
      4'd7:    w = 32'hFF7F7F7F;
      4'd8:    w = 32'hFF3F3F3F;
      4'd9:    w = 32'hFF0000FF;
      4'd10:   w = 32'hFF00FF00;
      4'd11:   w = 32'hFF00FFFF;
      4'd12:   w = 32'hFFFF0000;
      4'd13:   w = 32'hFFFF00FF;
      4'd14:   w = 32'hFFFFFF00;
      4'd15:   w = 32'hFFFFFFFF;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### hdl/pnq_pixel_if.sv
`timescale 1ns / 1ps
// Input channel of the quantizer: one operation with its pixel or entry data.
// Depends on pnq_pkg for field widths.
interface pnq_pixel_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [pnq_pkg::CH_W-1:0] entry_index;
  logic [pnq_pkg::CH_W-1:0] red;
  logic [pnq_pkg::CH_W-1:0] green;
  logic [pnq_pkg::CH_W-1:0] blue;
  logic [pnq_pkg::CH_W-1:0] alpha;
  logic                   last_pixel;

  modport source (output valid, func, entry_index, red, green, blue, alpha, last_pixel,
                  input ready);
  modport sink (input valid, func, entry_index, red, green, blue, alpha, last_pixel,
                output ready);
endinterface

### hdl/pnq_result_if.sv
`timescale 1ns / 1ps
// Output channel of the quantizer: selected index, entry color and alpha.
// Depends on pnq_pkg for field widths.
interface pnq_result_if;
  logic                   valid;
  logic                   ready;
  logic [pnq_pkg::CH_W-1:0] out_index;
  logic [pnq_pkg::CH_W-1:0] out_red;
  logic [pnq_pkg::CH_W-1:0] out_green;
  logic [pnq_pkg::CH_W-1:0] out_blue;
  logic [pnq_pkg::CH_W-1:0] out_alpha;
  logic                   out_last;

  modport source (output valid, out_index, out_red, out_green, out_blue, out_alpha, out_last,
                  input ready);
  modport sink (input valid, out_index, out_red, out_green, out_blue, out_alpha, out_last,
                output ready);
endinterface

### hdl/pnq_cell.sv
`timescale 1ns / 1ps
// One palette cell: holds one entry and runs two pipeline stages of the search.
// Depends on pnq_pkg.
module pnq_cell #(
  parameter int PALETTE_ENTRIES = pnq_pkg::DEF_ENTRIES,
  parameter int CELL_ID = 0,
  localparam int CW = $clog2(PALETTE_ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [CW-1:0]   count,
  input  logic            in_valid,
  input  pnq_pkg::item_t  in_item,
  output logic            out_valid,
  output pnq_pkg::item_t  out_item
);

  localparam logic HAS_DEFAULT = (CELL_ID < pnq_pkg::DEFAULT_COLORS);
  localparam logic [CW-1:0] ID_CNT = CW'(CELL_ID);
  localparam logic [pnq_pkg::CH_W-1:0] ID_SEL = pnq_pkg::CH_W'(CELL_ID);

  logic [pnq_pkg::WORD_W-1:0] entry;

  logic                        a_valid;
  pnq_pkg::item_t              a_item;
  logic [pnq_pkg::SQ_W-1:0]    a_sq_r;
  logic [pnq_pkg::SQ_W-1:0]    a_sq_g;
  logic [pnq_pkg::SQ_W-1:0]    a_sq_b;
  logic [pnq_pkg::WORD_W-1:0]  a_word;

  logic [pnq_pkg::CH_W-1:0]    d_r, d_g, d_b;
  logic [pnq_pkg::DIST_W-1:0]  sum;
  pnq_pkg::item_t              out_item_next;

  always_comb begin
    d_r = (in_item.red > entry[7:0]) ? in_item.red - entry[7:0] : entry[7:0] - in_item.red;
    d_g = (in_item.green > entry[15:8]) ? in_item.green - entry[15:8]
                                        : entry[15:8] - in_item.green;
    d_b = (in_item.blue > entry[23:16]) ? in_item.blue - entry[23:16]
                                        : entry[23:16] - in_item.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      if (HAS_DEFAULT) begin
        entry <= pnq_pkg::ega_color(4'(CELL_ID));
      end
    end else if (advance && in_valid && in_item.func == pnq_pkg::FUNC_LOAD &&
                 in_item.idx == ID_SEL) begin
      entry <= {in_item.alpha, in_item.blue, in_item.green, in_item.red};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item <= in_item;
      a_sq_r <= pnq_pkg::SQ_W'(d_r) * pnq_pkg::SQ_W'(d_r);
      a_sq_g <= pnq_pkg::SQ_W'(d_g) * pnq_pkg::SQ_W'(d_g);
      a_sq_b <= pnq_pkg::SQ_W'(d_b) * pnq_pkg::SQ_W'(d_b);
      a_word <= entry;
    end
  end

  // The lowest index wins a tie because later cells only take a strictly smaller distance.
  always_comb begin
    sum = pnq_pkg::DIST_W'(a_sq_r) + pnq_pkg::DIST_W'(a_sq_g) + pnq_pkg::DIST_W'(a_sq_b);
    out_item_next = a_item;
    if (a_item.func == pnq_pkg::FUNC_QUANT && ID_CNT < count && sum < a_item.best_dist) begin
      out_item_next.best_dist = sum;
      out_item_next.sel       = ID_SEL;
      out_item_next.word      = a_word;
    end
    if (a_item.func == pnq_pkg::FUNC_EXPAND && a_item.sel == ID_SEL) begin
      out_item_next.word = a_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= out_item_next;
    end
  end

endmodule

### hdl/palette_nearest_color_quantizer.sv
`timescale 1ns / 1ps
// Palette nearest-color quantizer: a row of palette cells that every item walks through.
// Takes one item per cycle while the result side does not stall.
// Each cell adds two stages; a stall on the result side holds the whole row.
// Reset clears all stages, loads the 16 default colors and sets the count to 16 (fewer if PALETTE_ENTRIES is smaller).
// Depends on pnq_pkg, pnq_pixel_if, pnq_result_if and pnq_cell.
module palette_nearest_color_quantizer #(
  parameter int PALETTE_ENTRIES = pnq_pkg::DEF_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pnq_pkg::ADDR_W-1:0]   paddr,
  input  logic [pnq_pkg::DATA_W-1:0]   pwdata,
  output logic [pnq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  pnq_pixel_if.sink                    pix_in,
  pnq_result_if.source                 pix_out
);

  localparam int CW = $clog2(PALETTE_ENTRIES + 1);
  localparam int RESET_COUNT = (PALETTE_ENTRIES < pnq_pkg::DEFAULT_COLORS) ?
                               PALETTE_ENTRIES : pnq_pkg::DEFAULT_COLORS;

  logic [pnq_pkg::COUNT_W-1:0] palette_count;
  logic [CW-1:0]               count_eff;
  logic                        advance;
  logic                        cfg_write;

  logic                        chain_valid [0:PALETTE_ENTRIES];
  pnq_pkg::item_t              chain_item  [0:PALETTE_ENTRIES];

  logic [pnq_pkg::COUNT_W-1:0] idx_ext;
  logic [pnq_pkg::COUNT_W-1:0] cnt_ext;

  logic                        m_valid;
  pnq_pkg::item_t              m_item;
  logic [pnq_pkg::PROD_W-1:0]  m_prod;

  logic [pnq_pkg::PROD_W:0]    scaled;
  logic [pnq_pkg::PROD_W:0]    quot;

  logic                        out_valid;
  logic [pnq_pkg::CH_W-1:0]    out_index, out_red, out_green, out_blue, out_alpha;
  logic                        out_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     paddr[2] == pnq_pkg::REG_PALETTE_COUNT;
  assign prdata    = (paddr[2] == pnq_pkg::REG_PALETTE_COUNT) ?
                     pnq_pkg::DATA_W'(palette_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= pnq_pkg::COUNT_W'(RESET_COUNT);
    end else if (cfg_write) begin
      palette_count <= pwdata[pnq_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    if (palette_count == '0) begin
      count_eff = CW'(1);
    end else if (palette_count > pnq_pkg::COUNT_W'(PALETTE_ENTRIES)) begin
      count_eff = CW'(PALETTE_ENTRIES);
    end else begin
      count_eff = palette_count[CW-1:0];
    end
  end

  assign advance      = !out_valid || pix_out.ready;
  assign pix_in.ready = advance;

  always_comb begin
    idx_ext = pnq_pkg::COUNT_W'(pix_in.entry_index);
    cnt_ext = pnq_pkg::COUNT_W'(count_eff);
    chain_valid[0]          = pix_in.valid;
    chain_item[0].func      = pix_in.func;
    chain_item[0].idx       = pix_in.entry_index;
    chain_item[0].red       = pix_in.red;
    chain_item[0].green     = pix_in.green;
    chain_item[0].blue      = pix_in.blue;
    chain_item[0].alpha     = pix_in.alpha;
    chain_item[0].last      = pix_in.last_pixel;
    chain_item[0].best_dist = '1;
    chain_item[0].word      = '0;
    chain_item[0].sel       = '0;
    if (pix_in.func == pnq_pkg::FUNC_EXPAND) begin
      chain_item[0].sel = (idx_ext >= cnt_ext) ? pnq_pkg::CH_W'(cnt_ext - 1'b1)
                                               : pix_in.entry_index;
    end
  end

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    pnq_cell #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES),
      .CELL_ID(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .count    (count_eff),
      .in_valid (chain_valid[g]),
      .in_item  (chain_item[g]),
      .out_valid(chain_valid[g+1]),
      .out_item (chain_item[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= chain_valid[PALETTE_ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_item <= chain_item[PALETTE_ENTRIES];
      m_prod <= pnq_pkg::PROD_W'(chain_item[PALETTE_ENTRIES].word[31:24]) *
                pnq_pkg::PROD_W'(chain_item[PALETTE_ENTRIES].alpha);
    end
  end

  // Rounded division by 255 of an 8-bit by 8-bit product, done with a shift and add.
  always_comb begin
    scaled = (pnq_pkg::PROD_W+1)'(m_prod) + (pnq_pkg::PROD_W+1)'(pnq_pkg::ALPHA_ROUND);
    quot   = (scaled + (scaled >> 8) + (pnq_pkg::PROD_W+1)'(1)) >> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= m_valid && (m_item.func == pnq_pkg::FUNC_QUANT ||
                               m_item.func == pnq_pkg::FUNC_EXPAND);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index <= m_item.sel;
      out_red   <= m_item.word[7:0];
      out_green <= m_item.word[15:8];
      out_blue  <= m_item.word[23:16];
      out_alpha <= (m_item.func == pnq_pkg::FUNC_EXPAND) ? quot[pnq_pkg::CH_W-1:0]
                                                         : m_item.alpha;
      out_last  <= m_item.last;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.out_index = out_index;
  assign pix_out.out_red   = out_red;
  assign pix_out.out_green = out_green;
  assign pix_out.out_blue  = out_blue;
  assign pix_out.out_alpha = out_alpha;
  assign pix_out.out_last  = out_last;

endmodule

### hdl/pnq_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the quantizer and the bind that attaches them.
// Depends on pnq_pkg and palette_nearest_color_quantizer.
module pnq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [40:0]                 out_payload,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready,
  input logic [pnq_pkg::ADDR_W-1:0]  paddr,
  input logic [pnq_pkg::DATA_W-1:0]  pwdata,
  input logic [pnq_pkg::DATA_W-1:0]  prdata
);

  // A synchronous reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // The input side stalls only while a result waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // A result held back keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
    else $error("stalled result changed");

  // A count written over the register port reads back.
  a_count_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == pnq_pkg::REG_PALETTE_COUNT) |=>
    (paddr[2] != pnq_pkg::REG_PALETTE_COUNT ||
     prdata[pnq_pkg::COUNT_W-1:0] == $past(pwdata[pnq_pkg::COUNT_W-1:0])))
    else $error("palette count readback mismatch");

endmodule

bind palette_nearest_color_quantizer pnq_checker u_pnq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .out_payload({pix_out.out_index, pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                pix_out.out_alpha, pix_out.out_last}),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .pready     (pready),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of palette_nearest_color_quantizer: load, quantize and expand
// transfers with random pacing, every result checked against a local palette predictor.
// Depends on pnq_pkg, pnq_pixel_if, pnq_result_if and the quantizer RTL.
module tb_top;
  import pnq_pkg::*;

  localparam int PIPE_LATENCY = 2 * DEF_ENTRIES + 2;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [ADDR_W-1:0] COUNT_ADDR = ADDR_W'(4 * int'(REG_PALETTE_COUNT));

  typedef struct packed {
    logic [1:0]      func;
    logic [CH_W-1:0] entry_index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last_pixel;
  } pixel_op_t;

  typedef struct packed {
    logic [CH_W-1:0] index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;
  } color_result_t;

  // Default colors as 24'hRRGGBB.
  localparam logic [23:0] EGA_RGB [DEFAULT_COLORS] = '{
    24'h000000, 24'h7F0000, 24'h007F00, 24'h7F7F00,
    24'h00007F, 24'h7F007F, 24'h007F7F, 24'h7F7F7F,
    24'h3F3F3F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pnq_pixel_if  pix_in ();
  pnq_result_if pix_out ();

  palette_nearest_color_quantizer dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  always #5 clk = ~clk;

  logic [WORD_W-1:0]  palette_shadow [DEF_ENTRIES];
  logic [COUNT_W-1:0] count_shadow;
  bit                 palette_filled;
  bit                 rush;
  int                 mismatch_count;
  color_result_t      pending_results [$];

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] got,
                             input logic [CH_W-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  function automatic int entries_in_use();
    int c;
    c = int'(count_shadow);
    if (c < 1) c = 1;
    if (c > DEF_ENTRIES) c = DEF_ENTRIES;
    return c;
  endfunction

  function automatic void reset_palette_shadow();
    int i;
    for (i = 0; i < DEF_ENTRIES; i++) begin
      palette_shadow[i] = '0;
    end
    for (i = 0; i < DEFAULT_COLORS; i++) begin
      palette_shadow[i] = {8'hFF, EGA_RGB[i][7:0], EGA_RGB[i][15:8], EGA_RGB[i][23:16]};
    end
    count_shadow = COUNT_W'(DEFAULT_COLORS);
    palette_filled = 1'b0;
  endfunction

  // Applies one operation to the shadow palette; returns 1 when it yields a result.
  function automatic bit predict_palette_op(input pixel_op_t op, output color_result_t res);
    int cnt, sel, best_d, d, dr, dg, db, i;
    logic [WORD_W-1:0] w;
    cnt = entries_in_use();
    res = '0;
    sel = 0;
    case (op.func)
      FUNC_LOAD: begin
        palette_shadow[op.entry_index] = {op.alpha, op.blue, op.green, op.red};
        return 1'b0;
      end
      FUNC_QUANT: begin
        best_d = 32'h7FFF_FFFF;
        for (i = 0; i < cnt; i++) begin
          w = palette_shadow[i];
          dr = int'(op.red) - int'(w[7:0]);
          dg = int'(op.green) - int'(w[15:8]);
          db = int'(op.blue) - int'(w[23:16]);
          d = dr * dr + dg * dg + db * db;
          if (d < best_d) begin
            best_d = d;
            sel = i;
          end
        end
        w = palette_shadow[sel];
        res.alpha = op.alpha;
      end
      FUNC_EXPAND: begin
        sel = (int'(op.entry_index) >= cnt) ? cnt - 1 : int'(op.entry_index);
        w = palette_shadow[sel];
        res.alpha = CH_W'((int'(w[31:24]) * int'(op.alpha) + ALPHA_ROUND) / 255);
      end
      default: begin
        return 1'b0;
      end
    endcase
    res.index = CH_W'(sel);
    res.red   = w[7:0];
    res.green = w[15:8];
    res.blue  = w[23:16];
    res.last  = op.last_pixel;
    return 1'b1;
  endfunction

  function automatic pixel_op_t make_op(input logic [1:0] func, input logic [CH_W-1:0] idx,
                                        input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                        input logic [CH_W-1:0] b, input logic [CH_W-1:0] a,
                                        input logic last);
    pixel_op_t op;
    op.func        = func;
    op.entry_index = idx;
    op.red         = r;
    op.green       = g;
    op.blue        = b;
    op.alpha       = a;
    op.last_pixel  = last;
    return op;
  endfunction

  function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] v);
    int x;
    x = int'(v) + $urandom_range(0, 6) - 3;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return CH_W'(x);
  endfunction

  function automatic logic [CH_W-1:0] rail();
    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
  endfunction

  function automatic pixel_op_t random_op();
    pixel_op_t op;
    int pick, cnt;
    logic [WORD_W-1:0] w;
    cnt = entries_in_use();
    pick = $urandom_range(0, 99);
    op = make_op(FUNC_QUANT, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                 CH_W'($urandom), CH_W'($urandom), 1'($urandom));
    if (pick < 15) op.func = FUNC_LOAD;
    else if (pick < 20) op.func = FUNC_NONE;
    else if (pick < 65) op.func = FUNC_QUANT;
    else op.func = FUNC_EXPAND;
    if ($urandom_range(0, 7) == 0) op.alpha = rail();
    w = palette_shadow[$urandom_range(0, cnt - 1)];
    pick = $urandom_range(0, 9);
    case (op.func)
      FUNC_LOAD: begin
        if (!palette_filled) op.entry_index = CH_W'($urandom_range(0, DEFAULT_COLORS - 1));
        if (pick < 3) {op.blue, op.green, op.red} = w[23:0];
      end
      FUNC_QUANT: begin
        if (pick < 4) begin
          op.red   = nudge(w[7:0]);
          op.green = nudge(w[15:8]);
          op.blue  = nudge(w[23:16]);
        end else if (pick < 6) begin
          op.red   = rail();
          op.green = rail();
          op.blue  = rail();
        end
      end
      FUNC_EXPAND: begin
        if (pick < 5) op.entry_index = CH_W'($urandom_range(0, cnt - 1));
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic send_op(input pixel_op_t op);
    int gap;
    color_result_t res;
    gap = rush ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid       <= 1'b1;
    pix_in.func        <= op.func;
    pix_in.entry_index <= op.entry_index;
    pix_in.red         <= op.red;
    pix_in.green       <= op.green;
    pix_in.blue        <= op.blue;
    pix_in.alpha       <= op.alpha;
    pix_in.last_pixel  <= op.last_pixel;
    @(posedge clk);
    while (pix_in.ready !== 1'b1) @(posedge clk);
    if (predict_palette_op(op, res)) pending_results.push_back(res);
  endtask

  task automatic run_random_ops(input int n);
    repeat (n) send_op(random_op());
  endtask

  // Loads give no result and may still be in the row when the last result leaves.
  task automatic drain_pipeline();
    pix_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_palette_count(input logic [DATA_W-1:0] value);
    drain_pipeline();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    count_shadow = value[COUNT_W-1:0];
  endtask

  task automatic test_default_palette();
    send_op(make_op(FUNC_QUANT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_op(make_op(FUNC_QUANT, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_op(make_op(FUNC_QUANT, 8'd3, 8'd70, 8'd60, 8'd66, 8'd1, 1'b0));
    send_op(make_op(FUNC_QUANT, 8'd9, 8'd200, 8'd30, 8'd20, 8'd128, 1'b1));
    send_op(make_op(FUNC_EXPAND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
    send_op(make_op(FUNC_EXPAND, 8'd15, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1));
    send_op(make_op(FUNC_EXPAND, 8'd16, 8'd12, 8'd34, 8'd56, 8'd128, 1'b0));
    send_op(make_op(FUNC_EXPAND, 8'd255, 8'd1, 8'd2, 8'd3, 8'd254, 1'b1));
    send_op(make_op(FUNC_NONE, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h99, 1'b1));
    // A duplicate of entry 1 makes a tie that the lower index must win.
    send_op(make_op(FUNC_LOAD, 8'd5, 8'd127, 8'd0, 8'd0, 8'd77, 1'b0));
    send_op(make_op(FUNC_QUANT, 8'd5, 8'd127, 8'd0, 8'd0, 8'd42, 1'b0));
    send_op(make_op(FUNC_EXPAND, 8'd5, 8'd0, 8'd0, 8'd0, 8'd200, 1'b1));
    send_op(make_op(FUNC_QUANT, 8'd0, 8'd64, 8'd64, 8'd64, 8'd255, 1'b0));
  endtask

  task automatic test_count_extremes();
    write_palette_count(32'd0);
    send_op(make_op(FUNC_QUANT, 8'd0, 8'd255, 8'd255, 8'd255, 8'd17, 1'b1));
    send_op(make_op(FUNC_EXPAND, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
    write_palette_count(32'd1);
    send_op(make_op(FUNC_QUANT, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0));
    write_palette_count(32'hFFFF_FE05);
    send_op(make_op(FUNC_QUANT, 8'd0, 8'd0, 8'd255, 8'd255, 8'd9, 1'b1));
    send_op(make_op(FUNC_EXPAND, 8'd200, 8'd0, 8'd0, 8'd0, 8'd100, 1'b0));
    write_palette_count(32'd2);
    send_op(make_op(FUNC_QUANT, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0, 1'b1));
  endtask

  task automatic test_default_random();
    write_palette_count(32'd16);
    run_random_ops(60);
    write_palette_count($urandom_range(3, 15));
    rush = 1'b1;
    run_random_ops(30);
    rush = 1'b0;
  endtask

  task automatic test_fill_palette();
    int i;
    pixel_op_t op;
    logic [WORD_W-1:0] w;
    for (i = DEFAULT_COLORS; i < DEF_ENTRIES; i++) begin
      op = make_op(FUNC_LOAD, CH_W'(i), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                   CH_W'($urandom), 1'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        w = palette_shadow[$urandom_range(0, i - 1)];
        {op.blue, op.green, op.red} = w[23:0];
      end
      send_op(op);
    end
    palette_filled = 1'b1;
  endtask

  task automatic test_full_palette_random();
    write_palette_count(32'd256);
    run_random_ops(100);
    write_palette_count(32'd511);
    rush = 1'b1;
    run_random_ops(50);
    rush = 1'b0;
  endtask

  task automatic test_count_sweep();
    write_palette_count($urandom_range(257, 510));
    run_random_ops(35);
    repeat (3) begin
      write_palette_count($urandom_range(17, 255));
      run_random_ops(35);
    end
  endtask

  initial begin : result_checker
    int stall;
    color_result_t got, want;
    pix_out.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
      @(posedge clk);
      while (pix_out.valid !== 1'b1) @(posedge clk);
      got.index = pix_out.out_index;
      got.red   = pix_out.out_red;
      got.green = pix_out.out_green;
      got.blue  = pix_out.out_blue;
      got.alpha = pix_out.out_alpha;
      got.last  = pix_out.out_last;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending, index %0h", got.index));
      end else begin
        want = pending_results.pop_front();
        check_field("out_index", got.index, want.index);
        check_field("out_red", got.red, want.red);
        check_field("out_green", got.green, want.green);
        check_field("out_blue", got.blue, want.blue);
        check_field("out_alpha", got.alpha, want.alpha);
        check_field("out_last", got.last, want.last);
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pix_in.valid       <= 1'b0;
    pix_in.func        <= FUNC_LOAD;
    pix_in.entry_index <= '0;
    pix_in.red         <= '0;
    pix_in.green       <= '0;
    pix_in.blue        <= '0;
    pix_in.alpha       <= '0;
    pix_in.last_pixel  <= 1'b0;
    rush = 1'b0;
    mismatch_count = 0;
    reset_palette_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_palette();
    test_count_extremes();
    test_default_random();
    test_fill_palette();
    test_full_palette_random();
    test_count_sweep();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hdl/pnq_pkg.sv
hdl/pnq_pixel_if.sv
hdl/pnq_result_if.sv
hdl/pnq_cell.sv
hdl/palette_nearest_color_quantizer.sv
hdl/pnq_checker.sv
verif/tb_top.sv
